/* rtl/core/dotq_pkg.sv */
// Shared types, codes and constants for the deadline-ordered task queue.
package dotq_pkg;

  localparam int unsigned DefaultDepth = 16;

  typedef enum logic [2:0] {
    CMD_INSERT      = 3'd0,
    CMD_CANCEL      = 3'd1,
    CMD_DEQUEUE     = 3'd2,
    CMD_DONE        = 3'd3,
    CMD_BAR_INSERT  = 3'd4,
    CMD_BAR_ACQUIRE = 3'd5,
    CMD_DISPOSE     = 3'd6
  } cmd_e;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_FULL        = 4'd1,
    ST_DISPOSED    = 4'd2,
    ST_NOT_FOUND   = 4'd3,
    ST_EMPTY       = 4'd4,
    ST_NOT_DUE     = 4'd5,
    ST_AT_LIMIT    = 4'd6,
    ST_BAR_FRONT   = 4'd7,
    ST_BAR_WAITING = 4'd8
  } status_e;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_NON_EMPTY = 2'd1,
    EV_EMPTY     = 2'd2
  } event_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE_MATCH,
    OP_REMOVE_FRONT,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ID_ZERO,
    ID_NEW,
    ID_FRONT,
    ID_TASK
  } id_sel_e;

  typedef enum logic [1:0] {
    PL_ZERO,
    PL_MATCH,
    PL_FRONT
  } pl_sel_e;

  typedef struct packed {
    logic [31:0] exec_time;
    logic [31:0] id;
    logic [15:0] payload;
    logic        barrier;
  } cell_t;

  typedef struct packed {
    logic    load;
    logic    exec;
    op_e     op;
    logic    barrier;
    logic    set_held;
    id_sel_e id_sel;
    pl_sel_e pl_sel;
  } ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic front_barrier;
    logic front_due;
    logic found;
    logic found_barrier;
    logic found_front;
    logic held_match;
  } sts_t;

endpackage

/* rtl/core/dotq_datapath.sv */
// Sorted cell row, id counter, held barrier id and result data registers.
module dotq_datapath import dotq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_t        ctl_i,
  input  logic [31:0] exec_time_i,
  input  logic [31:0] now_time_i,
  input  logic [31:0] task_id_i,
  input  logic [15:0] payload_i,
  output sts_t        sts_o,
  output logic [31:0] out_id_o,
  output logic [15:0] out_payload_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cell_t             cell_q [QUEUE_DEPTH];
  cell_t             prev_c [QUEUE_DEPTH];
  cell_t             next_c [QUEUE_DEPTH];
  cell_t             new_c;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [31:0]       id_cnt_q, new_id;
  logic [31:0]       held_id_q;
  logic [31:0]       time_q, now_q, tid_q, out_id_q;
  logic [15:0]       pl_q, out_pl_q, match_pl;
  logic [QUEUE_DEPTH-1:0] valid, gt, after, prev_after, match, macc, macc_prev, first;
  logic              found_bar;

  assign new_id = id_cnt_q + 32'd1;
  assign new_c  = '{exec_time: time_q, id: new_id,
                    payload: ctl_i.barrier ? 16'd0 : pl_q, barrier: ctl_i.barrier};

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign valid[i] = (CntW'(i) < cnt_q);
    assign gt[i]    = valid[i] && ((cell_q[i].exec_time > time_q) ||
                      ((cell_q[i].exec_time == time_q) && (cell_q[i].id > new_id)));
    assign after[i] = gt[i] | ~valid[i];
    assign match[i] = valid[i] && (cell_q[i].id == tid_q);
    if (i == 0) begin : g_head
      assign prev_c[i]     = new_c;
      assign prev_after[i] = 1'b0;
      assign macc_prev[i]  = 1'b0;
    end else begin : g_body
      assign prev_c[i]     = cell_q[i-1];
      assign prev_after[i] = after[i-1];
      assign macc_prev[i]  = macc[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign next_c[i] = cell_q[i];
    end else begin : g_mid
      assign next_c[i] = cell_q[i+1];
    end
    assign macc[i]  = macc_prev[i] | match[i];
    assign first[i] = match[i] & ~macc_prev[i];

    always_ff @(posedge clk_i) begin
      if (ctl_i.exec) begin
        case (ctl_i.op)
          OP_INSERT: begin
            // shift the tail up by one and drop the new task into the gap
            if (after[i]) cell_q[i] <= prev_after[i] ? prev_c[i] : new_c;
          end
          OP_REMOVE_MATCH: begin
            if (macc[i]) cell_q[i] <= next_c[i];
          end
          OP_REMOVE_FRONT: cell_q[i] <= next_c[i];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    match_pl  = '0;
    found_bar = 1'b0;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      match_pl  = match_pl | (cell_q[i].payload & {16{first[i]}});
      found_bar = found_bar | (first[i] & cell_q[i].barrier);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.exec) begin
      case (ctl_i.op)
        OP_INSERT:       cnt_d = cnt_q + CntW'(1);
        OP_REMOVE_MATCH,
        OP_REMOVE_FRONT: cnt_d = cnt_q - CntW'(1);
        OP_CLEAR:        cnt_d = '0;
        default:         cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      id_cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (ctl_i.exec && ctl_i.op == OP_INSERT) id_cnt_q <= new_id;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      time_q <= exec_time_i;
      now_q  <= now_time_i;
      tid_q  <= task_id_i;
      pl_q   <= payload_i;
    end
    if (ctl_i.exec && ctl_i.set_held) held_id_q <= tid_q;
    if (ctl_i.exec) begin
      case (ctl_i.id_sel)
        ID_NEW:   out_id_q <= new_id;
        ID_FRONT: out_id_q <= cell_q[0].id;
        ID_TASK:  out_id_q <= tid_q;
        default:  out_id_q <= '0;
      endcase
      case (ctl_i.pl_sel)
        PL_MATCH: out_pl_q <= match_pl;
        PL_FRONT: out_pl_q <= cell_q[0].payload;
        default:  out_pl_q <= '0;
      endcase
    end
  end

  assign sts_o.empty         = (cnt_q == '0);
  assign sts_o.full          = (cnt_q >= CntW'(QUEUE_DEPTH));
  assign sts_o.front_barrier = cell_q[0].barrier;
  assign sts_o.front_due     = (cell_q[0].exec_time <= now_q);
  assign sts_o.found         = |match;
  assign sts_o.found_barrier = found_bar;
  assign sts_o.found_front   = match[0];
  assign sts_o.held_match    = (held_id_q == tid_q);

  assign out_id_o      = out_id_q;
  assign out_payload_o = out_pl_q;

endmodule

/* rtl/core/dotq_ctrl.sv */
// Command sequencer: decides status, flags and running count per command.
module dotq_ctrl import dotq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  sts_t       sts_i,
  output ctl_t       ctl_o,
  output logic [3:0] status_o,
  output logic       is_first_o,
  output logic [1:0] queue_event_o,
  output logic [7:0] running_now_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_RESP = 3'b100
  } state_e;

  state_e     state_q, state_d;
  logic [2:0] cmd_q;
  logic [7:0] max_run_q, run_q, run_d;
  logic       first_q, first_d, empty_q, empty_d, disp_q, disp_d, held_q, held_d;
  status_e    status_q, status_d;
  event_e     ev_q, ev_d;
  logic       is_first_q, is_first_d;
  logic       exec;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);
  assign exec        = (state_q == S_EXEC);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_EXEC;
      S_EXEC:  state_d = S_RESP;
      S_RESP:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_o          = '0;
    ctl_o.op       = OP_NONE;
    ctl_o.id_sel   = ID_ZERO;
    ctl_o.pl_sel   = PL_ZERO;
    ctl_o.load     = in_valid_i && in_ready_o;
    ctl_o.exec     = exec;
    run_d          = run_q;
    first_d        = first_q;
    empty_d        = empty_q;
    disp_d         = disp_q;
    held_d         = held_q;
    status_d       = ST_OK;
    ev_d           = EV_NONE;
    is_first_d     = 1'b0;
    if (exec) begin
      case (cmd_q)
        CMD_INSERT, CMD_BAR_INSERT: begin
          if (disp_q) status_d = ST_DISPOSED;
          else if (sts_i.full) status_d = ST_FULL;
          else begin
            ctl_o.op      = OP_INSERT;
            ctl_o.id_sel  = ID_NEW;
            ctl_o.barrier = (cmd_q == CMD_BAR_INSERT);
            if (cmd_q == CMD_INSERT) begin
              is_first_d = first_q;
              first_d    = 1'b0;
              if (empty_q) begin
                empty_d = 1'b0;
                ev_d    = EV_NON_EMPTY;
              end
            end
          end
        end
        CMD_CANCEL: begin
          if (!sts_i.found) status_d = ST_NOT_FOUND;
          else begin
            ctl_o.op     = OP_REMOVE_MATCH;
            ctl_o.pl_sel = PL_MATCH;
            // release the held barrier
            if (sts_i.found_barrier && held_q && sts_i.held_match) begin
              held_d = 1'b0;
              if (run_q != 8'd0) run_d = run_q - 8'd1;
            end
          end
        end
        CMD_DEQUEUE: begin
          if (disp_q) status_d = ST_DISPOSED;
          else if (sts_i.empty) begin
            status_d = ST_EMPTY;
            if (!empty_q) begin
              empty_d = 1'b1;
              ev_d    = EV_EMPTY;
            end
          end else if (run_q >= max_run_q) status_d = ST_AT_LIMIT;
          else if (sts_i.front_barrier) status_d = ST_BAR_FRONT;
          else if (!sts_i.front_due) status_d = ST_NOT_DUE;
          else begin
            ctl_o.op     = OP_REMOVE_FRONT;
            ctl_o.id_sel = ID_FRONT;
            ctl_o.pl_sel = PL_FRONT;
            if (run_q != 8'd255) run_d = run_q + 8'd1;
          end
        end
        CMD_DONE: begin
          if (run_q != 8'd0) run_d = run_q - 8'd1;
        end
        CMD_BAR_ACQUIRE: begin
          if (disp_q) status_d = ST_DISPOSED;
          else if (!sts_i.found || !sts_i.found_barrier) status_d = ST_NOT_FOUND;
          else if (run_q != 8'd0 || !sts_i.found_front) status_d = ST_BAR_WAITING;
          else begin
            run_d          = 8'd1;
            held_d         = 1'b1;
            ctl_o.set_held = 1'b1;
            ctl_o.id_sel   = ID_TASK;
          end
        end
        CMD_DISPOSE: begin
          if (!disp_q) begin
            disp_d   = 1'b1;
            held_d   = 1'b0;
            ctl_o.op = OP_CLEAR;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      max_run_q  <= 8'd1;
      run_q      <= '0;
      first_q    <= 1'b1;
      empty_q    <= 1'b1;
      disp_q     <= 1'b0;
      held_q     <= 1'b0;
      cmd_q      <= '0;
      status_q   <= ST_OK;
      ev_q       <= EV_NONE;
      is_first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) max_run_q <= cfg_wdata_i;
      if (ctl_o.load) cmd_q <= cmd_i;
      run_q   <= run_d;
      first_q <= first_d;
      empty_q <= empty_d;
      disp_q  <= disp_d;
      held_q  <= held_d;
      if (exec) begin
        status_q   <= status_d;
        ev_q       <= ev_d;
        is_first_q <= is_first_d;
      end
    end
  end

  assign status_o      = status_q;
  assign is_first_o    = is_first_q;
  assign queue_event_o = ev_q;
  assign running_now_o = run_q;

endmodule

/* rtl/core/deadline_ordered_task_queue.sv */
// Top level of the deadline-ordered task queue.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one command with its
//   fields cmd_i, exec_time_i, now_time_i, task_id_i and payload_i.
//   Output channel (out_valid_o/out_ready_i) returns one result per command:
//   status_o, out_id_o, out_payload_o, is_first_o, queue_event_o, running_now_o.
//   cfg_we_i/cfg_wdata_i write max_running; write it only while idle.
// Timing:
//   A command is taken in the idle state, worked in the execute state on
//   the sorted cell row (parallel compare, shift of every cell) and its
//   result shows the cycle after. Result valid rises in the response state,
//   which follows the execute state; the next command is taken the cycle
//   after the result transfer, so no new command is taken before the result
//   of the last one has been transferred.
// Reset:
//   The table is empty, the id counter, running count and disposed mark are
//   clear, max_running is 1. Cell contents are not cleared; only cells below
//   the fill count are ever looked at.
// Stall:
//   While the receiver holds out_ready_i low the result stays put and no new
//   command is taken.
module deadline_ordered_task_queue import dotq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DefaultDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] exec_time_i,
  input  logic [31:0] now_time_i,
  input  logic [31:0] task_id_i,
  input  logic [15:0] payload_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  status_o,
  output logic [31:0] out_id_o,
  output logic [15:0] out_payload_o,
  output logic        is_first_o,
  output logic [1:0]  queue_event_o,
  output logic [7:0]  running_now_o,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i
);

  ctl_t ctl;
  sts_t sts;

  dotq_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .out_valid_o,
    .out_ready_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .sts_i         (sts),
    .ctl_o         (ctl),
    .status_o,
    .is_first_o,
    .queue_event_o,
    .running_now_o
  );

  dotq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .ctl_i         (ctl),
    .exec_time_i,
    .now_time_i,
    .task_id_i,
    .payload_i,
    .sts_o         (sts),
    .out_id_o,
    .out_payload_o
  );

endmodule
